[hw/rtl/p1305_pkg.sv]
// ----------------------------------------------------------------------------
// p1305_pkg
// Shared types and constants for the Poly1305 MAC engine.
// ----------------------------------------------------------------------------
package p1305_pkg;

    localparam int LIMB_W   = 26;
    localparam int ACC_W    = 27;
    localparam int NUM_LIMB = 5;
    localparam int ROW_W    = 3;

    localparam logic [LIMB_W-1:0] LIMB_MASK = 26'h3ffffff;
    localparam logic [LIMB_W-1:0] CLAMP_R0  = 26'h3ffffff;
    localparam logic [LIMB_W-1:0] CLAMP_R1  = 26'h3ffff03;
    localparam logic [LIMB_W-1:0] CLAMP_R2  = 26'h3ffc0ff;
    localparam logic [LIMB_W-1:0] CLAMP_R3  = 26'h3f03fff;
    localparam logic [LIMB_W-1:0] CLAMP_R4  = 26'h00fffff;
    localparam logic [LIMB_W-1:0] HI_BIT    = 26'h1000000;

    localparam logic [1:0] REG_R_LOW  = 2'd0;
    localparam logic [1:0] REG_R_HIGH = 2'd1;
    localparam logic [1:0] REG_S_LOW  = 2'd2;
    localparam logic [1:0] REG_S_HIGH = 2'd3;

    typedef struct packed {
        logic             accept;
        logic             load;
        logic             row;
        logic [ROW_W-1:0] row_idx;
        logic             fix;
        logic             fin1;
        logic             fin2;
        logic             fin3;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_status;

endpackage

[hw/rtl/p1305_ctrl.sv]
// ----------------------------------------------------------------------------
// p1305_ctrl
// Sequencer: load, five multiply rows, carry fix, and the three finish steps.
// ----------------------------------------------------------------------------
module p1305_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    input  logic [4:0]         i_in_count,
    input  logic               i_out_ready,
    input  p1305_pkg::t_status i_status,
    output logic               o_in_ready,
    output p1305_pkg::t_cmd    o_cmd
);
    import p1305_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LOAD = 7'b0000010,
        ST_ROW  = 7'b0000100,
        ST_FIX  = 7'b0001000,
        ST_FIN1 = 7'b0010000,
        ST_FIN2 = 7'b0100000,
        ST_FIN3 = 7'b1000000
    } t_state;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_last, n_last;
    logic             w_accept;
    logic             w_out_free;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = o_in_ready && i_in_valid;
    assign w_out_free = !i_status.out_full || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_last  = r_last;
        o_cmd   = '0;
        o_cmd.row_idx = r_row;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.accept = 1'b1;
                    n_last = i_in_last;
                    if (i_in_last && (i_in_count == 5'd0)) begin
                        n_state = ST_FIN1;
                    end else begin
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_row = '0;
                n_state = ST_ROW;
            end
            ST_ROW: begin
                o_cmd.row = 1'b1;
                n_row = r_row + 1'b1;
                if (r_row == ROW_W'(NUM_LIMB - 1)) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                o_cmd.fix = 1'b1;
                n_state = r_last ? ST_FIN1 : ST_IDLE;
            end
            ST_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state = ST_FIN2;
            end
            ST_FIN2: begin
                o_cmd.fin2 = 1'b1;
                n_state = ST_FIN3;
            end
            ST_FIN3: begin
                if (w_out_free) begin
                    o_cmd.fin3 = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_last  <= n_last;
        end
    end

endmodule

[hw/rtl/p1305_dp.sv]
// ----------------------------------------------------------------------------
// p1305_dp
// Datapath: key registers, limb accumulator, row multiplier, finish, tag out.
// ----------------------------------------------------------------------------
module p1305_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  p1305_pkg::t_cmd    i_cmd,
    output p1305_pkg::t_status o_status,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_sel,
    input  logic [63:0]        i_cfg_data,
    input  logic [63:0]        i_data_low,
    input  logic [63:0]        i_data_high,
    input  logic [4:0]         i_byte_count,
    input  logic               i_last_block,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [127:0]       o_tag
);
    import p1305_pkg::*;

    logic [63:0]        r_key_r_lo, r_key_r_hi, r_key_s_lo, r_key_s_hi;
    logic [127:0]       r_msg;
    logic               r_top;
    logic [ACC_W-1:0]   r_h   [NUM_LIMB];
    logic [ACC_W:0]     r_hp  [NUM_LIMB];
    logic [LIMB_W-1:0]  r_r   [NUM_LIMB];
    logic [LIMB_W+2:0]  r_s5  [NUM_LIMB];
    logic [37:0]        r_c;
    logic               r_out_valid;
    logic [127:0]       r_tag;

    logic [127:0]       w_key_r;
    logic [127:0]       w_msg;
    logic [127:0]       w_pad;
    logic [LIMB_W-1:0]  w_m   [NUM_LIMB];
    logic [LIMB_W-1:0]  w_rl  [NUM_LIMB];
    logic [63:0]        w_sum;
    logic [63:0]        w_t;
    logic [41:0]        w_fix;
    logic [ACC_W-1:0]   w_f   [NUM_LIMB];
    logic [ACC_W-1:0]   w_g   [NUM_LIMB];
    logic               w_take_g;
    logic [63:0]        w_lo, w_hi, w_tlo;
    logic [64:0]        w_add_lo;

    assign o_status.out_full = r_out_valid;
    assign o_out_valid       = r_out_valid;
    assign o_tag             = r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_r_lo <= '0;
            r_key_r_hi <= '0;
            r_key_s_lo <= '0;
            r_key_s_hi <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_sel)
                REG_R_LOW:  r_key_r_lo <= i_cfg_data;
                REG_R_HIGH: r_key_r_hi <= i_cfg_data;
                REG_S_LOW:  r_key_s_lo <= i_cfg_data;
                REG_S_HIGH: r_key_s_hi <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pad a short tail with 0x01 then zeros
    assign w_msg = {i_data_high, i_data_low};
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < i_byte_count) begin
                w_pad[i*8 +: 8] = w_msg[i*8 +: 8];
            end else if (5'(i) == i_byte_count) begin
                w_pad[i*8 +: 8] = 8'h01;
            end else begin
                w_pad[i*8 +: 8] = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (i_last_block && (i_byte_count < 5'd16)) begin
                r_msg <= w_pad;
                r_top <= 1'b0;
            end else begin
                r_msg <= w_msg;
                r_top <= 1'b1;
            end
        end
    end

    assign w_key_r = {r_key_r_hi, r_key_r_lo};
    always_comb begin
        for (int i = 0; i < NUM_LIMB - 1; i++) begin
            w_m[i]  = r_msg[i*LIMB_W +: LIMB_W];
            w_rl[i] = w_key_r[i*LIMB_W +: LIMB_W];
        end
        w_m[NUM_LIMB-1]  = {2'b00, r_msg[127:104]} | (r_top ? HI_BIT : '0);
        w_rl[NUM_LIMB-1] = {2'b00, w_key_r[127:104]};
    end

    // one product row: d_k = sum h_j * r_(k-j), wrapped terms use 5*r
    always_comb begin
        w_sum = '0;
        for (int j = 0; j < NUM_LIMB; j++) begin
            if (ROW_W'(j) <= i_cmd.row_idx) begin
                w_sum = w_sum + 64'(r_hp[j] * r_r[i_cmd.row_idx - ROW_W'(j)]);
            end else begin
                w_sum = w_sum + 64'(r_hp[j] * r_s5[ROW_W'(NUM_LIMB) + i_cmd.row_idx
                                                    - ROW_W'(j)]);
            end
        end
        w_t = w_sum + 64'(r_c);
    end

    assign w_fix = 42'(r_h[0]) + 42'(r_c) * 42'd5;

    // carry through h1..h4, fold into h0
    always_comb begin
        logic [ACC_W:0] t;
        logic           c;
        logic [ACC_W:0] t0;
        c = 1'b0;
        w_f[0] = r_h[0];
        for (int i = 1; i < NUM_LIMB; i++) begin
            t = {1'b0, r_h[i]} + {{ACC_W{1'b0}}, c};
            c = t[LIMB_W];
            w_f[i] = {1'b0, t[LIMB_W-1:0]};
        end
        t0 = {1'b0, r_h[0]} + (c ? (ACC_W+1)'(5) : '0);
        w_f[0] = {1'b0, t0[LIMB_W-1:0]};
        w_f[1] = w_f[1] + {{(ACC_W-1){1'b0}}, t0[LIMB_W]};
    end

    // g = h + 5 - 2^130
    always_comb begin
        logic [ACC_W:0] t;
        logic           c;
        t = {1'b0, r_h[0]} + (ACC_W+1)'(5);
        c = t[LIMB_W];
        w_g[0] = {1'b0, t[LIMB_W-1:0]};
        for (int i = 1; i < NUM_LIMB - 1; i++) begin
            t = {1'b0, r_h[i]} + {{ACC_W{1'b0}}, c};
            c = t[LIMB_W];
            w_g[i] = {1'b0, t[LIMB_W-1:0]};
        end
        t = {1'b0, r_h[NUM_LIMB-1]} + {{ACC_W{1'b0}}, c};
        w_take_g = (t >= (ACC_W+1)'(1 << LIMB_W));
        w_g[NUM_LIMB-1] = t[ACC_W-1:0] - ACC_W'(1 << LIMB_W);
    end

    assign w_lo = 64'(r_h[0]) | (64'(r_h[1]) << 26) | (64'(r_h[2]) << 52);
    assign w_hi = (64'(r_h[2]) >> 12) | (64'(r_h[3]) << 14) | (64'(r_h[4]) << 40);
    assign w_add_lo = {1'b0, w_lo} + {1'b0, r_key_s_lo};
    assign w_tlo = w_hi + r_key_s_hi + {63'd0, w_add_lo[64]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_c <= '0;
            for (int i = 0; i < NUM_LIMB; i++) begin
                r_hp[i] <= {1'b0, r_h[i]} + (ACC_W+1)'(w_m[i]);
            end
            r_r[0] <= w_rl[0] & CLAMP_R0;
            r_r[1] <= w_rl[1] & CLAMP_R1;
            r_r[2] <= w_rl[2] & CLAMP_R2;
            r_r[3] <= w_rl[3] & CLAMP_R3;
            r_r[4] <= w_rl[4] & CLAMP_R4;
            r_s5[0] <= '0;
            r_s5[1] <= (LIMB_W+3)'(w_rl[1] & CLAMP_R1) * (LIMB_W+3)'(5);
            r_s5[2] <= (LIMB_W+3)'(w_rl[2] & CLAMP_R2) * (LIMB_W+3)'(5);
            r_s5[3] <= (LIMB_W+3)'(w_rl[3] & CLAMP_R3) * (LIMB_W+3)'(5);
            r_s5[4] <= (LIMB_W+3)'(w_rl[4] & CLAMP_R4) * (LIMB_W+3)'(5);
        end else if (i_cmd.row) begin
            r_c <= w_t[63:26];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LIMB; i++) begin
                r_h[i] <= '0;
            end
        end else if (i_cmd.row) begin
            r_h[i_cmd.row_idx] <= {1'b0, w_t[LIMB_W-1:0]};
        end else if (i_cmd.fix) begin
            r_h[0] <= {1'b0, w_fix[LIMB_W-1:0]};
            r_h[1] <= r_h[1] + ACC_W'(w_fix[41:26]);
        end else if (i_cmd.fin1) begin
            for (int i = 0; i < NUM_LIMB; i++) begin
                r_h[i] <= w_f[i];
            end
        end else if (i_cmd.fin2) begin
            if (w_take_g) begin
                for (int i = 0; i < NUM_LIMB; i++) begin
                    r_h[i] <= w_g[i];
                end
            end
        end else if (i_cmd.fin3) begin
            for (int i = 0; i < NUM_LIMB; i++) begin
                r_h[i] <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin3) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin3) begin
            r_tag <= {w_tlo, w_add_lo[63:0]};
        end
    end

endmodule

[hw/rtl/poly1305_mac_engine.sv]
// ----------------------------------------------------------------------------
// poly1305_mac_engine
// Poly1305 one-time authenticator over 16-byte message words.
// ----------------------------------------------------------------------------
// Load the key through the config channel (index 0 r low, 1 r high, 2 s low,
// 3 s high) while the engine is idle; r is clamped internally.
// Each slave word carries one 16-byte block; tlast ends the message. On the
// last word, a byte count of 1 to 15 pads the tail, 0 absorbs nothing.
// A block runs from accept to next ready through a load step, five
// multiply rows on the shared limb multiplier, and one carry fold.
// A last word adds the finish steps, and the tag appears on the master side.
// A last word with count 0 goes straight to the finish steps.
// The tag waits in an output register; the next block is accepted while it
// waits, but a following last word holds in its final step until the tag
// is taken. Reset clears the key, the accumulator and the output.
// ----------------------------------------------------------------------------
module poly1305_mac_engine (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [135:0] s_axis_tdata,  // data_low, data_high, byte_count, zero pad
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // tag_low, tag_high
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [7:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);
    import p1305_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_cfg_we;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && (i_cfg_index[7:2] == 6'd0);

    p1305_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .i_in_count  (s_axis_tdata[132:128]),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_cmd       (w_cmd)
    );

    p1305_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_we     (w_cfg_we),
        .i_cfg_sel    (i_cfg_index[1:0]),
        .i_cfg_data   (i_cfg_data),
        .i_data_low   (s_axis_tdata[63:0]),
        .i_data_high  (s_axis_tdata[127:64]),
        .i_byte_count (s_axis_tdata[132:128]),
        .i_last_block (s_axis_tlast),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_tag        (m_axis_tdata)
    );

endmodule

[dv/poly1305_mac_engine_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// poly1305_mac_engine_tb
// Self-checking bench for the Poly1305 MAC engine. A directed table covers
// the reset key, a zero r with a known pad, and the tail lengths around each
// half-block boundary on the largest clamped key. Random messages under
// changing keys follow. Each tag is checked against its table tag where one
// is given, else a 130-bit modular predictor, with bursty input, random
// output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module poly1305_mac_engine_tb;
    import p1305_pkg::*;

    localparam int          IDLE_LIMIT  = 3000;
    localparam int          DRAIN_WAIT  = 24;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [263:0] PRIME      = (264'd1 << 130) - 264'd5;
    localparam logic [127:0] R_CLAMP    = 128'h0ffffffc0ffffffc0ffffffc0fffffff;
    localparam logic [63:0]  ONES       = 64'hffff_ffff_ffff_ffff;
    localparam logic [127:0] S_PAD      = 128'h8000_0000_0000_0001_ffff_ffff_ffff_fffe;

    typedef struct packed {
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [4:0]   cnt;
        logic         last;
        logic         typed;
        logic [127:0] tag;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = '0;  // data_low, data_high, byte_count, zero pad
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;       // tag_low, tag_high
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [7:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data = '0;

    logic [63:0]  key_r_lo, key_r_hi, key_s_lo, key_s_hi;
    logic [129:0] poly_acc;
    logic [127:0] tag_expect_q[$];
    int           errors = 0;
    int           words_in = 0;
    int           tags_seen = 0;
    int           burst_left = 0;
    int           idle_cycles = 0;
    bit           hold_req = 1'b0;

    t_row dir_rows[18] = '{
        '{64'h0, 64'h0, 5'd0, 1'b1, 1'b1, 128'h0},
        '{ONES, ONES, 5'd16, 1'b1, 1'b1, 128'h0},
        '{ONES, ONES, 5'd3, 1'b0, 1'b0, 128'h0},
        '{ONES, ONES, 5'd7, 1'b1, 1'b1, S_PAD},
        '{ONES, ONES, 5'd31, 1'b1, 1'b1, S_PAD},
        '{64'h0, 64'h0, 5'd0, 1'b1, 1'b1, S_PAD},
        '{64'h0, 64'h0, 5'd0, 1'b1, 1'b0, 128'h0},
        '{64'h0, 64'h0, 5'd0, 1'b0, 1'b0, 128'h0},
        '{ONES, ONES, 5'd16, 1'b0, 1'b0, 128'h0},
        '{ONES, ONES, 5'd1, 1'b1, 1'b0, 128'h0},
        '{ONES, ONES, 5'd7, 1'b1, 1'b0, 128'h0},
        '{ONES, ONES, 5'd8, 1'b1, 1'b0, 128'h0},
        '{ONES, ONES, 5'd9, 1'b1, 1'b0, 128'h0},
        '{ONES, ONES, 5'd15, 1'b1, 1'b0, 128'h0},
        '{ONES, ONES, 5'd16, 1'b1, 1'b0, 128'h0},
        '{ONES, 64'h0, 5'd17, 1'b1, 1'b0, 128'h0},
        '{ONES, ONES, 5'd31, 1'b0, 1'b0, 128'h0},
        '{64'h0123_4567_89ab_cdef, ONES, 5'd8, 1'b1, 1'b0, 128'h0}
    };

    poly1305_mac_engine u_dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic poly_word(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] cnt, input logic last,
                             output bit has_tag, output logic [127:0] tag);
        logic [127:0] blk;
        logic [263:0] sum;
        logic [263:0] prod;
        blk = {hi, lo};
        has_tag = last;
        tag = '0;
        if (!last || cnt >= 5'd16) begin
            sum = {134'b0, poly_acc} + {136'b0, blk} + (264'd1 << 128);
        end else if (cnt != 5'd0) begin
            blk = (blk & ((128'd1 << (cnt * 8)) - 128'd1)) | (128'd1 << (cnt * 8));
            sum = {134'b0, poly_acc} + {136'b0, blk};
        end else begin
            sum = {134'b0, poly_acc};
        end
        if (!last || cnt != 5'd0) begin
            prod = sum * {136'b0, {key_r_hi, key_r_lo} & R_CLAMP};
            poly_acc = 130'(prod % PRIME);
        end
        if (last) begin
            tag = poly_acc[127:0] + {key_s_hi, key_s_lo};
            poly_acc = '0;
        end
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            8'(REG_R_LOW):  key_r_lo = val;
            8'(REG_R_HIGH): key_r_hi = val;
            8'(REG_S_LOW):  key_s_lo = val;
            8'(REG_S_HIGH): key_s_hi = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_key(input logic [127:0] r, input logic [127:0] s);
        cfg_write(8'(REG_R_LOW), r[63:0]);
        cfg_write(8'(REG_R_HIGH), r[127:64]);
        cfg_write(8'(REG_S_LOW), s[63:0]);
        cfg_write(8'(REG_S_HIGH), s[127:64]);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (tag_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic send_word(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] cnt, input logic last,
                             input logic typed, input logic [127:0] typed_tag);
        bit           has_tag;
        logic [127:0] tag;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {3'b0, cnt, hi, lo};
        s_axis_tlast = last;
        do @(posedge i_clk); while (!s_axis_tready);
        words_in++;
        poly_word(lo, hi, cnt, last, has_tag, tag);
        if (has_tag) tag_expect_q.push_back(typed ? typed_tag : tag);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(6)) @(negedge i_clk);
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(8);
        end
    endtask

    function automatic logic [63:0] rand_half();
        case ($urandom_range(7))
            0: return '0;
            1: return ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // receiver: own stall pattern, plus one long hold-off on request
    initial begin
        int mode;
        forever begin
            if (hold_req) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            mode = $urandom_range(3);
            repeat ($urandom_range(80, 10)) begin
                @(negedge i_clk);
                case (mode)
                    0: m_axis_tready = 1'b1;
                    1: m_axis_tready = $urandom_range(1);
                    2: m_axis_tready = ($urandom_range(3) == 0);
                    default: m_axis_tready = ($urandom_range(15) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        logic [127:0] want;
        if (m_axis_tvalid && m_axis_tready) begin
            tags_seen++;
            if (tag_expect_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected tag %h", $time, m_axis_tdata);
            end else begin
                want = tag_expect_q.pop_front();
                if (m_axis_tdata[63:0] !== want[63:0]) begin
                    errors++;
                    $display("%0t: tag_low expected %h actual %h",
                             $time, want[63:0], m_axis_tdata[63:0]);
                end
                if (m_axis_tdata[127:64] !== want[127:64]) begin
                    errors++;
                    $display("%0t: tag_high expected %h actual %h",
                             $time, want[127:64], m_axis_tdata[127:64]);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, %0d tags outstanding", $time, tag_expect_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int           msg_len;
        logic [127:0] r_key;
        logic [127:0] s_key;
        key_r_lo = '0;
        key_r_hi = '0;
        key_s_lo = '0;
        key_s_hi = '0;
        poly_acc = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            if (i == 2) begin
                wait_idle();
                load_key(128'h0, S_PAD);
            end else if (i == 6) begin
                wait_idle();
                load_key({ONES, ONES}, {ONES, ONES});
                cfg_write(8'd4, 64'h0);
                cfg_write(8'hff, 64'h0);
            end
            send_word(dir_rows[i].lo, dir_rows[i].hi, dir_rows[i].cnt,
                      dir_rows[i].last, dir_rows[i].typed, dir_rows[i].tag);
        end

        for (int phase = 0; phase < 8; phase++) begin
            wait_idle();
            case (phase)
                0: begin r_key = '0; s_key = '0; end
                1: begin r_key = {ONES, ONES}; s_key = '0; end
                2: begin r_key = '0; s_key = {ONES, ONES}; end
                default: begin
                    r_key = {rand_half(), rand_half()};
                    s_key = {rand_half(), rand_half()};
                end
            endcase
            load_key(r_key, s_key);
            if (phase == 3) hold_req = 1'b1;
            while (words_in < 18 + (phase + 1) * 150) begin
                msg_len = ($urandom_range(4) == 0) ? $urandom_range(12, 1) : $urandom_range(3, 1);
                for (int k = 1; k < msg_len; k++)
                    send_word(rand_half(), rand_half(), 5'($urandom), 1'b0, 1'b0, '0);
                send_word(rand_half(), rand_half(),
                          ($urandom_range(5) == 0) ? 5'($urandom_range(31, 16))
                                                   : 5'($urandom_range(16)),
                          1'b1, 1'b0, '0);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait_idle();
        $display("Sent %0d message words under 11 key settings, checked %0d tags,",
                 words_in, tags_seen);
        $display("with every tail length, bursty input and stalled output.");
        if (errors == 0 && tag_expect_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d tags missing", errors, tag_expect_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/p1305_pkg.sv
hw/rtl/p1305_ctrl.sv
hw/rtl/p1305_dp.sv
hw/rtl/poly1305_mac_engine.sv
dv/poly1305_mac_engine_tb.sv
